// ===== rtl/mfr_pkg.sv =====
`default_nettype none

package mfr_pkg;

  // Frame layout
  localparam int unsigned FRAME_BYTES = 20;
  localparam int unsigned CMD_AT      = 2;
  localparam int unsigned COUNT_AT    = 3;
  localparam int unsigned PAYLOAD_AT  = 5;
  localparam int unsigned PAYLOAD_LEN = 15;

  localparam logic [7:0] HDR_BYTE0 = 8'h55;
  localparam logic [7:0] HDR_BYTE1 = 8'hAA;

  // Byte counter: counts 0..FRAME_BYTES+1, saturating
  localparam int unsigned BC_W = 5;
  // Payload step counter
  localparam int unsigned PC_W = 4;

  // Result kinds carried on tuser
  localparam logic [1:0] KIND_ACCEPT  = 2'd0;
  localparam logic [1:0] KIND_REJECT  = 2'd1;
  localparam logic [1:0] KIND_MESSAGE = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic take_byte;   // store the incoming beat
    logic eval;        // check the frame and load the ack/reject result
    logic append;      // write one payload byte into the message store
    logic emit_rd;     // read one message store slot
    logic emit_load;   // load the read slot into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_end;   // beat closes a write of exactly FRAME_BYTES bytes
    logic frame_ok;    // frame passes all checks
    logic final_frame; // accepted frame completes the message
    logic append_last; // last payload byte is being written
    logic emit_last;   // last message slot is being loaded
    logic out_free;    // output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/mfr_ctrl.sv =====
`default_nettype none

module mfr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  wire mfr_pkg::sts_t sts_i,
  output mfr_pkg::cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_EVAL    = 5'b00010,
    ST_APPEND  = 5'b00100,
    ST_EMIT_RD = 5'b01000,
    ST_EMIT_WR = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Sequence one frame: check, append payload, walk the store on completion
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.take_byte = s_axis_tvalid_i;
        if (sts_i.frame_end) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.out_free) begin
          cmd_o.eval = 1'b1;
          state_d    = sts_i.frame_ok ? ST_APPEND : ST_IDLE;
        end
      end
      ST_APPEND: begin
        cmd_o.append = 1'b1;
        if (sts_i.append_last) begin
          state_d = sts_i.final_frame ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          state_d         = sts_i.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mfr_dpath.sv =====
`default_nettype none

module mfr_dpath #(
  parameter int unsigned MESSAGE_BYTES = 48
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mfr_pkg::cmd_t cmd_i,
  output mfr_pkg::sts_t      sts_o,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          write_end_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [1:0]         out_kind_o,
  output logic [7:0]         out_command_o,
  output logic [7:0]         out_message_byte_o,
  output logic               out_last_o
);

  localparam int unsigned AW = $clog2(MESSAGE_BYTES);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MESSAGE_BYTES - 1);
  localparam logic [mfr_pkg::BC_W-1:0] BC_LAST =
    mfr_pkg::BC_W'(mfr_pkg::FRAME_BYTES - 1);
  localparam logic [mfr_pkg::BC_W-1:0] BC_FULL =
    mfr_pkg::BC_W'(mfr_pkg::FRAME_BYTES);
  localparam logic [mfr_pkg::PC_W-1:0] PC_LAST =
    mfr_pkg::PC_W'(mfr_pkg::PAYLOAD_LEN - 1);

  logic [7:0] frame_q [mfr_pkg::FRAME_BYTES];
  logic [mfr_pkg::BC_W-1:0] byte_count_q;
  logic [7:0] packs_left_q;
  logic [7:0] prev_cmd_q;
  logic [7:0] prev_packs_q;
  logic       final_q;
  logic [AW-1:0] append_idx_q;
  logic [mfr_pkg::PC_W-1:0] pay_idx_q;
  logic [AW-1:0] emit_idx_q;

  logic [7:0] msg_mem [MESSAGE_BYTES];
  logic [MESSAGE_BYTES-1:0] msg_valid_q;
  logic [7:0] rd_data_q;
  logic       rd_valid_q;

  logic       out_valid_q;
  logic [1:0] out_kind_q;
  logic [7:0] out_cmd_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic [7:0] frm_cmd;
  logic [7:0] frm_count;
  logic [7:0] packs_loaded;
  logic       frame_ok;
  logic       out_free;
  logic       msg_clear;
  logic [mfr_pkg::BC_W-1:0] pay_addr;

  // Frame checks
  assign frm_cmd      = frame_q[mfr_pkg::CMD_AT];
  assign frm_count    = frame_q[mfr_pkg::COUNT_AT];
  assign packs_loaded = (packs_left_q == 8'd0) ? frm_count : packs_left_q;
  assign frame_ok     = (frame_q[0] == mfr_pkg::HDR_BYTE0)
                     && (frame_q[1] == mfr_pkg::HDR_BYTE1)
                     && !((frm_cmd != prev_cmd_q) && (prev_packs_q != 8'd0))
                     && (frm_count == packs_loaded);

  assign out_free  = !out_valid_q || out_ready_i;
  assign msg_clear = (cmd_i.eval && !frame_ok) || (cmd_i.emit_load && emit_idx_q == LAST_SLOT);
  assign pay_addr  = mfr_pkg::BC_W'(mfr_pkg::PAYLOAD_AT) + mfr_pkg::BC_W'(pay_idx_q);

  always_comb begin
    sts_o             = '0;
    sts_o.frame_end   = cmd_i.take_byte && write_end_i && (byte_count_q == BC_LAST);
    sts_o.frame_ok    = frame_ok;
    sts_o.final_frame = final_q;
    sts_o.append_last = (pay_idx_q == PC_LAST);
    sts_o.emit_last   = (emit_idx_q == LAST_SLOT);
    sts_o.out_free    = out_free;
  end

  // Capture the bytes of the current write
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && byte_count_q < BC_FULL) begin
      frame_q[byte_count_q] <= rx_byte_i;
    end
  end

  // Count bytes of the write, saturating one past a full frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
    end else if (cmd_i.take_byte) begin
      if (write_end_i) begin
        byte_count_q <= '0;
      end else if (byte_count_q <= BC_FULL) begin
        byte_count_q <= byte_count_q + 1'b1;
      end
    end
  end

  // Run tracking: pack counter, last accepted command and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packs_left_q <= '0;
      prev_cmd_q   <= '0;
      prev_packs_q <= '0;
      final_q      <= 1'b0;
    end else if (cmd_i.eval) begin
      final_q <= (packs_loaded == 8'd0);
      if (frame_ok) begin
        prev_cmd_q   <= frm_cmd;
        prev_packs_q <= packs_loaded;
        packs_left_q <= (packs_loaded == 8'd0) ? 8'd0 : packs_loaded - 8'd1;
      end else begin
        packs_left_q <= packs_loaded;
      end
    end
  end

  // Step through payload bytes and message slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pay_idx_q    <= '0;
      emit_idx_q   <= '0;
      append_idx_q <= '0;
    end else begin
      if (cmd_i.eval) begin
        pay_idx_q <= '0;
      end else if (cmd_i.append) begin
        pay_idx_q <= pay_idx_q + 1'b1;
      end
      if (cmd_i.eval) begin
        emit_idx_q <= '0;
      end else if (cmd_i.emit_load) begin
        emit_idx_q <= (emit_idx_q == LAST_SLOT) ? '0 : emit_idx_q + 1'b1;
      end
      if (msg_clear) begin
        append_idx_q <= '0;
      end else if (cmd_i.append && append_idx_q != LAST_SLOT) begin
        append_idx_q <= append_idx_q + 1'b1;
      end
    end
  end

  // Message store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      msg_mem[append_idx_q] <= frame_q[pay_addr];
    end
    if (cmd_i.emit_rd) begin
      rd_data_q <= msg_mem[emit_idx_q];
    end
  end

  // Slot valid bits; an unwritten slot reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (msg_clear) begin
        msg_valid_q <= '0;
      end else if (cmd_i.append) begin
        msg_valid_q[append_idx_q] <= 1'b1;
      end
      if (cmd_i.emit_rd) begin
        rd_valid_q <= msg_valid_q[emit_idx_q];
      end
    end
  end

  // Output register: hold the result until the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.eval || cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      out_kind_q <= frame_ok ? mfr_pkg::KIND_ACCEPT : mfr_pkg::KIND_REJECT;
      out_cmd_q  <= frm_cmd;
      out_byte_q <= 8'd0;
      out_last_q <= !frame_ok || (packs_loaded != 8'd0);
    end else if (cmd_i.emit_load) begin
      out_kind_q <= mfr_pkg::KIND_MESSAGE;
      out_cmd_q  <= prev_cmd_q;
      out_byte_q <= rd_valid_q ? rd_data_q : 8'd0;
      out_last_q <= (emit_idx_q == LAST_SLOT);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_kind_o         = out_kind_q;
  assign out_command_o      = out_cmd_q;
  assign out_message_byte_o = out_byte_q;
  assign out_last_o         = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/multi_frame_message_reassembler_core.sv =====
`default_nettype none

// Multi-frame message reassembler. Bytes of received writes arrive one beat
// per cycle on the slave side while the block is idle, tlast marking the
// final byte of a write; only writes of exactly 20 bytes (55 AA, command,
// frames-to-come count, spare byte, 15 payload bytes) are acted on. Each such
// frame yields one ack or reject beat; accepted payloads are appended to a
// message store of MESSAGE_BYTES slots (the last slot absorbs overflow), and
// the frame whose count reaches zero is followed by MESSAGE_BYTES message
// beats, slot 0 first. The closing byte of a full frame holds the input
// while the frame is checked and an accepted payload is appended (one
// message store write per cycle); a completing frame then walks the store,
// each message beat taking a registered store read, then an output load.
// Output back-pressure stretches the checking and the walk. The store is
// cleared at once through per-slot valid bits, so the block needs no
// clearing pass after reset.
module multi_frame_message_reassembler_core #(
  parameter int unsigned MESSAGE_BYTES = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  input  wire logic        s_axis_tlast_i,  // write_end
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // [7:0] command, [15:8] message_byte
  output logic [1:0]       m_axis_tuser_o,  // [1:0] kind
  output logic             m_axis_tlast_o   // last
);

  mfr_pkg::cmd_t cmd;
  mfr_pkg::sts_t sts;
  logic [7:0] out_command;
  logic [7:0] out_message_byte;

  mfr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  mfr_dpath #(
    .MESSAGE_BYTES (MESSAGE_BYTES)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .rx_byte_i          (s_axis_tdata_i),
    .write_end_i        (s_axis_tlast_i),
    .out_valid_o        (m_axis_tvalid_o),
    .out_ready_i        (m_axis_tready_i),
    .out_kind_o         (m_axis_tuser_o),
    .out_command_o      (out_command),
    .out_message_byte_o (out_message_byte),
    .out_last_o         (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {out_message_byte, out_command};

endmodule

`default_nettype wire

// ===== tb/sv/multi_frame_message_reassembler_core_tb.sv =====
`default_nettype none

module multi_frame_message_reassembler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MESSAGE_BYTES = 48;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] command;
    logic [7:0] msg_byte;
    logic       last;
  } out_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        s_last = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // Mirror of the block state
  logic [7:0]  rx_frame [mfr_pkg::FRAME_BYTES];
  logic [mfr_pkg::BC_W-1:0] rx_len = '0;
  logic [7:0]  frames_due = 8'h00;
  logic [7:0]  run_cmd = 8'h00;
  logic [7:0]  run_due = 8'h00;
  logic [7:0]  msg_buf [MESSAGE_BYTES];
  int          msg_wr_ptr = 0;

  out_beat_t   due_beats [$];
  out_beat_t   want_beat;
  out_beat_t   got_beat;

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int n_errors = 0;
  int bytes_sent = 0;
  int n_acks = 0;
  int n_rejects = 0;
  int n_msg_beats = 0;
  int n_messages = 0;

  multi_frame_message_reassembler_core #(
    .MESSAGE_BYTES(MESSAGE_BYTES)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #1 clk_i = ~clk_i;

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Empty the message store and rewind the append pointer
  task automatic clear_message();
    for (int i = 0; i < MESSAGE_BYTES; i++) msg_buf[i] = 8'h00;
    msg_wr_ptr = 0;
  endtask

  task automatic push_beat(input logic [1:0] kind, input logic [7:0] cmd,
                           input logic [7:0] data, input logic last);
    out_beat_t b;
    b.kind = kind;
    b.command = cmd;
    b.msg_byte = data;
    b.last = last;
    due_beats.push_back(b);
  endtask

  // Track one accepted byte and queue the beats it will cause
  task automatic reassemble_byte(input logic [7:0] b, input logic eow);
    logic [7:0] cmd;
    logic [7:0] cnt;
    logic       ok;
    if (rx_len < mfr_pkg::FRAME_BYTES) rx_frame[rx_len] = b;
    if (rx_len <= mfr_pkg::FRAME_BYTES) rx_len = rx_len + 1'b1;
    if (!eow) return;
    if (rx_len != mfr_pkg::FRAME_BYTES) begin
      rx_len = '0;
      return;
    end
    rx_len = '0;
    cmd = rx_frame[mfr_pkg::CMD_AT];
    cnt = rx_frame[mfr_pkg::COUNT_AT];
    if (frames_due == 8'h00) frames_due = cnt;
    ok = (rx_frame[0] == mfr_pkg::HDR_BYTE0) && (rx_frame[1] == mfr_pkg::HDR_BYTE1);
    if (ok && cmd != run_cmd && run_due != 8'h00) ok = 1'b0;
    if (ok && cnt != frames_due) ok = 1'b0;
    if (!ok) begin
      clear_message();
      push_beat(mfr_pkg::KIND_REJECT, cmd, 8'h00, 1'b1);
      return;
    end
    run_cmd = cmd;
    run_due = frames_due;
    // Append payload; the last slot absorbs overflow
    for (int i = 0; i < mfr_pkg::PAYLOAD_LEN; i++) begin
      msg_buf[msg_wr_ptr] = rx_frame[mfr_pkg::PAYLOAD_AT + i];
      if (msg_wr_ptr < MESSAGE_BYTES - 1) msg_wr_ptr++;
    end
    if (frames_due != 8'h00) begin
      frames_due = frames_due - 8'h01;
      push_beat(mfr_pkg::KIND_ACCEPT, cmd, 8'h00, 1'b1);
    end else begin
      push_beat(mfr_pkg::KIND_ACCEPT, cmd, 8'h00, 1'b0);
      for (int i = 0; i < MESSAGE_BYTES; i++) begin
        push_beat(mfr_pkg::KIND_MESSAGE, cmd, msg_buf[i], i == MESSAGE_BYTES - 1);
      end
      clear_message();
    end
  endtask

  // Drive one byte beat and wait for it to be taken
  task automatic send_byte(input logic [7:0] b, input logic eow);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= eow;
    do @(posedge clk_i); while (!s_axis_tready_o);
    reassemble_byte(b, eow);
    bytes_sent++;
  endtask

  // fill: 0 random payload, 1 all zeros, 2 all ones, 3 alternating
  task automatic send_frame(input logic [7:0] h0, input logic [7:0] h1,
                            input logic [7:0] cmd, input logic [7:0] cnt,
                            input int fill);
    logic [7:0] frame [mfr_pkg::FRAME_BYTES];
    frame[0] = h0;
    frame[1] = h1;
    frame[mfr_pkg::CMD_AT] = cmd;
    frame[mfr_pkg::COUNT_AT] = cnt;
    frame[4] = 8'($urandom);
    for (int i = mfr_pkg::PAYLOAD_AT; i < mfr_pkg::FRAME_BYTES; i++) begin
      case (fill)
        1: frame[i] = 8'h00;
        2: frame[i] = 8'hFF;
        3: frame[i] = i[0] ? 8'hFF : 8'h00;
        default: frame[i] = 8'($urandom);
      endcase
    end
    for (int i = 0; i < mfr_pkg::FRAME_BYTES; i++) begin
      send_byte(frame[i], i == mfr_pkg::FRAME_BYTES - 1);
    end
  endtask

  // Random write; a full-length one never loads a nonzero frame count
  task automatic send_junk(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (len == mfr_pkg::FRAME_BYTES && i == mfr_pkg::COUNT_AT && frames_due == 8'h00) begin
        b = 8'h00;
      end
      send_byte(b, i == len - 1);
    end
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got_beat.kind = m_axis_tuser_o;
      got_beat.command = m_axis_tdata_o[7:0];
      got_beat.msg_byte = m_axis_tdata_o[15:8];
      got_beat.last = m_axis_tlast_o;
      if (due_beats.size() == 0) begin
        $error("unexpected result beat: kind %0d command %h", got_beat.kind,
               got_beat.command);
        n_errors++;
      end else begin
        want_beat = due_beats.pop_front();
        if (got_beat.kind !== want_beat.kind) begin
          $error("kind: expected %0d, got %0d", want_beat.kind, got_beat.kind);
          n_errors++;
        end
        if (got_beat.command !== want_beat.command) begin
          $error("command: expected %h, got %h", want_beat.command, got_beat.command);
          n_errors++;
        end
        if (got_beat.msg_byte !== want_beat.msg_byte) begin
          $error("message_byte: expected %h, got %h", want_beat.msg_byte,
                 got_beat.msg_byte);
          n_errors++;
        end
        if (got_beat.last !== want_beat.last) begin
          $error("last: expected %0b, got %0b", want_beat.last, got_beat.last);
          n_errors++;
        end
        case (want_beat.kind)
          mfr_pkg::KIND_ACCEPT: n_acks++;
          mfr_pkg::KIND_REJECT: n_rejects++;
          default: begin
            n_msg_beats++;
            if (want_beat.last) n_messages++;
          end
        endcase
      end
    end
  end

  // Writes shorter or longer than a frame must stay silent
  task automatic test_wrong_lengths();
    send_junk(1);
    send_junk(mfr_pkg::FRAME_BYTES + 1);
  endtask

  // Single-frame message with extreme command and payload values
  task automatic test_single_frame_message();
    send_frame(mfr_pkg::HDR_BYTE0, mfr_pkg::HDR_BYTE1, 8'hFF, 8'h00, 2);
  endtask

  // Inside an open run: command change, count out of step, bad header;
  // the run stays open with three frames still to come
  task automatic test_frame_rejects();
    send_frame(mfr_pkg::HDR_BYTE0, mfr_pkg::HDR_BYTE1, 8'h3C, 8'h04, 1);
    send_frame(mfr_pkg::HDR_BYTE0, mfr_pkg::HDR_BYTE1, 8'h3D, 8'h03, 0);
    send_frame(mfr_pkg::HDR_BYTE0, mfr_pkg::HDR_BYTE1, 8'h3C, 8'h09, 0);
    send_frame(8'h54, mfr_pkg::HDR_BYTE1, 8'h3C, 8'h03, 0);
  endtask

  // Close the open run; four frames overflow the store, the fourth piling payload into the last slot
  task automatic test_overflow_run();
    for (int f = 3; f >= 0; f--) begin
      send_frame(mfr_pkg::HDR_BYTE0, mfr_pkg::HDR_BYTE1, 8'h3C, 8'(f), (f == 1) ? 3 : 0);
    end
  endtask

  initial begin
    clear_message();
    for (int i = 0; i < mfr_pkg::FRAME_BYTES; i++) rx_frame[i] = 8'h00;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 16;
    receiver_idle_pct = 76;
    test_wrong_lengths();
    test_single_frame_message();
    sender_idle_pct = 76;
    receiver_idle_pct = 16;
    test_frame_rejects();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_overflow_run();
    s_valid <= 1'b0;

    // Drain, then allow for a full message walk
    while (due_beats.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (due_beats.size() != 0) begin
      $error("%0d expected result beats never arrived", due_beats.size());
      n_errors++;
    end
    $display("Covered %0d input bytes: %0d acks, %0d rejects, %0d messages (%0d beats).",
             bytes_sent, n_acks, n_rejects, n_messages, n_msg_beats);
    if (n_errors == 0) begin
      $display("[multi_frame_message_reassembler_core] OK");
    end else begin
      $display("[multi_frame_message_reassembler_core] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Timed out with %0d result beats outstanding.", due_beats.size());
    $display("[multi_frame_message_reassembler_core] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
